FILE: rtl/otb_pkg.sv
// otb_pkg: shared types and constants for the one-shot timer bank
// used by otb_cell and one_shot_timer_bank; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package otb_pkg;

  localparam int MASK_W = 8;
  localparam int SLOT_W = 3;
  localparam int DUR_W  = 8;
  localparam int OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_DECLARE = 2'd0,
    OP_START   = 2'd1,
    OP_DELETE  = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  // one request travelling down the row of cells, masks build up on the way
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [DUR_W-1:0]  duration;
    logic [MASK_W-1:0] expired;
    logic [MASK_W-1:0] active;
  } otb_stage_t;

endpackage

`default_nettype wire

FILE: rtl/one_shot_timer_bank.sv
// one_shot_timer_bank: top level, a row of NUM_SLOTS timer cells
// depends on otb_pkg and otb_cell
`timescale 1ns / 1ps
`default_nettype none

// a bank of one-shot countdown timers, one cell per slot
// requests: in_op picks declare, start, delete or tick; in_slot names the
//   slot for the first three, in_duration is the count stored on declare
// a request is taken at a rising edge with start high and busy low; busy is
//   always low, the row takes a new request every cycle
// each request walks the row one cell per cycle; every cell applies it to
//   its own slot and ors its expiry and active bits into the masks
// each cell registers the request, so out_valid follows the register of the
//   last cell in the row; throughput: one request per cycle
// each request yields exactly one result, shown for one cycle with out_valid
//   high: out_expired_mask (tick only, else zero) and out_active_mask
// requests overtake nothing, so every cell sees them in order and the
//   results leave in the order the requests came in
// the receiver cannot stall; a result is taken in the cycle it is shown
// reset (rst_n low, synchronous) clears all durations, counts and active
//   flags and drops any request still in the row
// slots at index 8 and up cannot be named by the 3-bit in_slot, so they never start, and do not appear in the masks

module one_shot_timer_bank import otb_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [DUR_W-1:0]  in_duration,
  output logic                   out_valid,
  output logic [MASK_W-1:0]      out_expired_mask,
  output logic [MASK_W-1:0]      out_active_mask
);

  // stage[0] is the incoming request, stage[k+1] leaves cell k
  otb_stage_t stage [NUM_SLOTS+1];

  // the row is fully pipelined, so it never holds requests off
  assign busy = 1'b0;

  always_comb begin
    stage[0].valid    = start && !busy;
    stage[0].op       = op_t'(in_op);
    stage[0].slot     = in_slot;
    stage[0].duration = in_duration;
    stage[0].expired  = '0;
    stage[0].active   = '0;
  end

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    otb_cell #(
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (stage[k]),
      .stage_out (stage[k+1])
    );
  end

  assign out_valid        = stage[NUM_SLOTS].valid;
  assign out_expired_mask = stage[NUM_SLOTS].expired;
  assign out_active_mask  = stage[NUM_SLOTS].active;

  // an expired slot is never reported active in the same result
  a_exp_not_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_expired_mask & out_active_mask) == '0))
    else $error("slot both expired and active");

  // only a tick can report an expiry
  a_exp_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (stage[NUM_SLOTS].op != OP_TICK)) |-> (out_expired_mask == '0))
    else $error("expiry reported on a non-tick request");

  // every accepted request comes out after the row latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##NUM_SLOTS out_valid)
    else $error("result missing after row latency");

endmodule

`default_nettype wire

FILE: rtl/otb_cell.sv
// otb_cell: one timer slot, holds duration, count and active flag
// applies each passing request and hands it on to the next cell; uses otb_pkg
`timescale 1ns / 1ps
`default_nettype none

module otb_cell import otb_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire otb_stage_t stage_in,
  output otb_stage_t      stage_out
);

  localparam logic [MASK_W-1:0] BIT = (IDX < MASK_W) ? MASK_W'(1 << IDX) : '0;

  logic [DUR_W-1:0] dur_r, dur_nxt;
  logic [DUR_W-1:0] cnt_r, cnt_nxt;
  logic             act_r, act_nxt;
  logic             exp_now;
  logic             hit;
  otb_stage_t       stage_r, stage_nxt;

  assign hit = stage_in.valid && (32'(stage_in.slot) == 32'(IDX));

  always_comb begin
    dur_nxt = dur_r;
    cnt_nxt = cnt_r;
    act_nxt = act_r;
    exp_now = 1'b0;
    if (stage_in.valid) begin
      unique case (stage_in.op)
        OP_DECLARE: begin
          if (hit) dur_nxt = stage_in.duration;
        end
        OP_START: begin
          if (hit) begin
            cnt_nxt = dur_r;
            act_nxt = 1'b1;
          end
        end
        OP_DELETE: begin
          if (hit) begin
            dur_nxt = '0;
            cnt_nxt = '0;
            act_nxt = 1'b0;
          end
        end
        OP_TICK: begin
          if (act_r) begin
            // zero and one both expire on this tick
            if (cnt_r <= DUR_W'(1)) begin
              cnt_nxt = '0;
              act_nxt = 1'b0;
              exp_now = 1'b1;
            end else begin
              cnt_nxt = cnt_r - DUR_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stage_nxt = stage_in;
    if (exp_now) stage_nxt.expired = stage_in.expired | BIT;
    if (act_nxt) stage_nxt.active = stage_in.active | BIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r   <= '0;
      cnt_r   <= '0;
      act_r   <= 1'b0;
      stage_r <= '0;
    end else begin
      dur_r   <= dur_nxt;
      cnt_r   <= cnt_nxt;
      act_r   <= act_nxt;
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire
